@@ hdl/rjdl_pkg.sv @@
// rjdl_pkg: shared types and fixed constants of the jitter delay line
// no dependencies; used by front, fifo, back and the top level

package rjdl_pkg;

  localparam int CH_W       = 3;
  localparam int DRAW_W     = 16;
  localparam int JIT_W      = 28;
  localparam int FRAC_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 28;
  localparam int COUNT_FLD_W = 4;
  localparam int SIZE_FLD_W = 13;
  localparam int SIZE_RST   = 960;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_SIZE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_JITTER_DEPTH  = 2'd2;

  typedef struct packed {
    logic [CH_W-1:0] ch;
    logic            active;
    logic            first;
    logic            last;
  } item_cls_t;

  typedef struct packed {
    logic count_wr;
    logic size_wr;
  } cfg_evt_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_JIT,
    ST_POS,
    ST_RD0,
    ST_RD1,
    ST_MUL,
    ST_OUT
  } back_state_t;

endpackage

@@ hdl/rjdl_front.sv @@
// rjdl_front: configuration registers, input classification and jitter scaling
// depends on rjdl_pkg

module rjdl_front #(
  parameter int MAX_CHANNELS = 8,
  parameter int STORE_DEPTH  = 4096,
  parameter int SAMPLE_BITS  = 24
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [rjdl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rjdl_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [rjdl_pkg::CH_W-1:0]           in_channel,
  input  logic signed [SAMPLE_BITS-1:0]       in_sample_in,
  input  logic [rjdl_pkg::DRAW_W-1:0]         in_random_draw,
  input  logic                                q_full,
  input  logic                                clearing,
  output logic                                push,
  output rjdl_pkg::item_cls_t                 push_cls,
  output logic [rjdl_pkg::JIT_W-1:0]          push_jit,
  output logic [SAMPLE_BITS-1:0]              push_sample,
  output logic [$clog2(STORE_DEPTH+1)-1:0]    size,
  output logic [$clog2(STORE_DEPTH+1)-1:0]    size_new,
  output rjdl_pkg::cfg_evt_t                  evt
);

  localparam int CNT_W = $clog2(MAX_CHANNELS + 1);
  localparam int SZ_W  = $clog2(STORE_DEPTH + 1);
  localparam int PROD_W = rjdl_pkg::DRAW_W + rjdl_pkg::JIT_W;
  localparam logic [SZ_W-1:0] SIZE_RST_V =
    SZ_W'((rjdl_pkg::SIZE_RST > STORE_DEPTH) ? STORE_DEPTH : rjdl_pkg::SIZE_RST);

  logic [CNT_W-1:0]               count_r, count_nxt, count_new;
  logic [SZ_W-1:0]                size_r, size_nxt;
  logic [rjdl_pkg::JIT_W-1:0]     depth_r, depth_nxt;
  logic [rjdl_pkg::COUNT_FLD_W-1:0] cnt_fld;
  logic [rjdl_pkg::SIZE_FLD_W-1:0]  size_fld;
  logic [PROD_W-1:0]              prod;

  always_comb begin
    cnt_fld  = cfg_wdata[rjdl_pkg::COUNT_FLD_W-1:0];
    size_fld = cfg_wdata[rjdl_pkg::SIZE_FLD_W-1:0];
    if (cnt_fld == '0) begin
      count_new = CNT_W'(1);
    end else if (int'(cnt_fld) > MAX_CHANNELS) begin
      count_new = CNT_W'(MAX_CHANNELS);
    end else begin
      count_new = CNT_W'(cnt_fld);
    end
    if (size_fld == '0) begin
      size_new = SZ_W'(1);
    end else if (int'(size_fld) > STORE_DEPTH) begin
      size_new = SZ_W'(STORE_DEPTH);
    end else begin
      size_new = SZ_W'(size_fld);
    end
    evt.count_wr = cfg_we && (cfg_index == rjdl_pkg::CFG_CHANNEL_COUNT);
    evt.size_wr  = cfg_we && (cfg_index == rjdl_pkg::CFG_BUFFER_SIZE);
    count_nxt = evt.count_wr ? count_new : count_r;
    size_nxt  = evt.size_wr ? size_new : size_r;
    depth_nxt = (cfg_we && (cfg_index == rjdl_pkg::CFG_JITTER_DEPTH)) ?
                cfg_wdata[rjdl_pkg::JIT_W-1:0] : depth_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= CNT_W'(1);
      size_r  <= SIZE_RST_V;
      depth_r <= '0;
    end else begin
      count_r <= count_nxt;
      size_r  <= size_nxt;
      depth_r <= depth_nxt;
    end
  end

  // classify the incoming transaction and scale the draw
  always_comb begin
    in_ready = !q_full && !clearing && !evt.count_wr;
    push     = in_valid && in_ready;
    push_cls.ch     = in_channel;
    push_cls.active = (int'(in_channel) < int'(count_r)) &&
                      (int'(in_channel) < MAX_CHANNELS);
    push_cls.first  = (in_channel == '0);
    push_cls.last   = (int'(in_channel) + 1 == int'(count_r));
    prod        = PROD_W'(in_random_draw) * PROD_W'(depth_r);
    push_jit    = prod[rjdl_pkg::FRAC_W +: rjdl_pkg::JIT_W];
    push_sample = in_sample_in;
  end

  assign size = size_r;

endmodule

@@ hdl/rjdl_fifo.sv @@
// rjdl_fifo: short queue between the front and back sections
// depends on rjdl_pkg for its depth

module rjdl_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PTR_W = (rjdl_pkg::QUEUE_DEPTH > 1) ? $clog2(rjdl_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(rjdl_pkg::QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] entry_r [rjdl_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    full  = (cnt_r == CNT_W'(rjdl_pkg::QUEUE_DEPTH));
    empty = (cnt_r == '0);
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (int'(wr_ptr_r) == rjdl_pkg::QUEUE_DEPTH - 1) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (int'(rd_ptr_r) == rjdl_pkg::QUEUE_DEPTH - 1) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data = entry_r[rd_ptr_r];

endmodule

@@ hdl/rjdl_ram.sv @@
// rjdl_ram: generic single write, single read memory with registered read
// no dependencies

module rjdl_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/rjdl_back.sv @@
// rjdl_back: delay position, store access, interpolation and result register
// depends on rjdl_pkg and rjdl_ram

module rjdl_back #(
  parameter int MAX_CHANNELS = 8,
  parameter int STORE_DEPTH  = 4096,
  parameter int SAMPLE_BITS  = 24
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  rjdl_pkg::cfg_evt_t                evt,
  input  logic [$clog2(STORE_DEPTH+1)-1:0]  size,
  input  logic [$clog2(STORE_DEPTH+1)-1:0]  size_new,
  input  logic                              q_empty,
  output logic                              q_pop,
  input  rjdl_pkg::item_cls_t               q_cls,
  input  logic [rjdl_pkg::JIT_W-1:0]        q_jit,
  input  logic [SAMPLE_BITS-1:0]            q_sample,
  output logic                              clearing,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [rjdl_pkg::CH_W-1:0]         out_ch,
  output logic signed [SAMPLE_BITS-1:0]     out_sample
);

  localparam int IDX_W     = $clog2(STORE_DEPTH);
  localparam int SZ_W      = $clog2(STORE_DEPTH + 1);
  localparam int POS_W     = SZ_W + rjdl_pkg::FRAC_W;
  localparam int CMP_W     = (POS_W > rjdl_pkg::JIT_W) ? POS_W : rjdl_pkg::JIT_W;
  localparam int MEM_DEPTH = MAX_CHANNELS * STORE_DEPTH;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);
  localparam int PW        = SAMPLE_BITS + rjdl_pkg::FRAC_W + 2;
  localparam logic signed [PW-1:0] HALF = PW'(1) << (rjdl_pkg::FRAC_W - 1);

  rjdl_pkg::back_state_t state_r, state_nxt;

  logic [MEM_AW-1:0]              clr_addr_r, clr_addr_nxt;
  logic [IDX_W-1:0]               wp_r, wp_nxt, ri_r, ri_nxt;
  logic [rjdl_pkg::FRAC_W-1:0]    frac_r, frac_nxt;
  logic [POS_W-1:0]               jit_r, jit_nxt;
  rjdl_pkg::item_cls_t            cls_r, cls_nxt;
  logic [rjdl_pkg::JIT_W-1:0]     ijit_r, ijit_nxt;
  logic [SAMPLE_BITS-1:0]         isample_r, isample_nxt;
  logic [SAMPLE_BITS-1:0]         first_r, first_nxt;
  logic signed [PW-1:0]           prod_r, prod_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [rjdl_pkg::CH_W-1:0]      out_ch_r, out_ch_nxt;
  logic [SAMPLE_BITS-1:0]         out_sample_r, out_sample_nxt;

  logic                           ram_we;
  logic [MEM_AW-1:0]              ram_waddr, ram_raddr, base;
  logic [SAMPLE_BITS-1:0]         ram_wdata, ram_rdata;

  logic [POS_W-1:0]               span, wp16;
  logic [POS_W:0]                 pos_wide;
  logic [POS_W-1:0]               pos;
  logic [SZ_W-1:0]                ri_inc;
  logic [IDX_W-1:0]               ri_next;
  logic signed [SAMPLE_BITS:0]    diff;
  logic signed [rjdl_pkg::FRAC_W:0] frac_s;
  logic signed [PW-1:0]           biased, step;
  logic                           out_free;

  rjdl_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(MEM_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    wp_nxt         = wp_r;
    ri_nxt         = ri_r;
    frac_nxt       = frac_r;
    jit_nxt        = jit_r;
    cls_nxt        = cls_r;
    ijit_nxt       = ijit_r;
    isample_nxt    = isample_r;
    first_nxt      = first_r;
    prod_nxt       = prod_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_ch_nxt     = out_ch_r;
    out_sample_nxt = out_sample_r;
    q_pop          = 1'b0;
    ram_we         = 1'b0;
    ram_wdata      = isample_r;
    out_free       = !out_valid_r || out_ready;

    base      = MEM_AW'(cls_r.ch) * MEM_AW'(STORE_DEPTH);
    ram_waddr = base + MEM_AW'(wp_r);
    ram_raddr = base + MEM_AW'(ri_r);

    span     = {size, {rjdl_pkg::FRAC_W{1'b0}}};
    wp16     = POS_W'({wp_r, {rjdl_pkg::FRAC_W{1'b0}}});
    if (wp16 >= jit_r) begin
      pos_wide = {1'b0, wp16} - {1'b0, jit_r};
    end else begin
      pos_wide = {1'b0, wp16} + {1'b0, span} - {1'b0, jit_r};
    end
    pos      = pos_wide[POS_W-1:0];

    ri_inc   = SZ_W'(ri_r) + 1'b1;
    ri_next  = (ri_inc >= size) ? '0 : ri_inc[IDX_W-1:0];

    diff     = {ram_rdata[SAMPLE_BITS-1], ram_rdata} - {first_r[SAMPLE_BITS-1], first_r};
    frac_s   = {1'b0, frac_r};
    biased   = prod_r + HALF;
    step     = biased >>> rjdl_pkg::FRAC_W;

    case (state_r)
      rjdl_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_r;
        ram_wdata = '0;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == MEM_AW'(MEM_DEPTH - 1)) begin
          state_nxt = rjdl_pkg::ST_IDLE;
        end
      end
      rjdl_pkg::ST_IDLE: begin
        if (!q_empty) begin
          q_pop       = 1'b1;
          cls_nxt     = q_cls;
          ijit_nxt    = q_jit;
          isample_nxt = q_sample;
          if (!q_cls.active) begin
            state_nxt = rjdl_pkg::ST_OUT;
          end else if (q_cls.first) begin
            state_nxt = rjdl_pkg::ST_JIT;
          end else begin
            state_nxt = rjdl_pkg::ST_RD0;
          end
        end
      end
      rjdl_pkg::ST_JIT: begin
        // saturate the jitter just below the buffer span
        if (CMP_W'(ijit_r) >= CMP_W'(span)) begin
          jit_nxt = span - 1'b1;
        end else begin
          jit_nxt = POS_W'(ijit_r);
        end
        state_nxt = rjdl_pkg::ST_POS;
      end
      rjdl_pkg::ST_POS: begin
        ri_nxt    = pos[rjdl_pkg::FRAC_W +: IDX_W];
        frac_nxt  = pos[rjdl_pkg::FRAC_W-1:0];
        state_nxt = rjdl_pkg::ST_RD0;
      end
      rjdl_pkg::ST_RD0: begin
        ram_we    = 1'b1;
        state_nxt = rjdl_pkg::ST_RD1;
      end
      rjdl_pkg::ST_RD1: begin
        ram_raddr = base + MEM_AW'(ri_next);
        // read at the write address returns the new sample
        first_nxt = (ri_r == wp_r) ? isample_r : ram_rdata;
        state_nxt = rjdl_pkg::ST_MUL;
      end
      rjdl_pkg::ST_MUL: begin
        prod_nxt  = PW'(diff) * PW'(frac_s);
        state_nxt = rjdl_pkg::ST_OUT;
      end
      rjdl_pkg::ST_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_ch_nxt    = cls_r.ch;
          out_sample_nxt = cls_r.active ? first_r + step[SAMPLE_BITS-1:0] : '0;
          if (cls_r.active && cls_r.last) begin
            wp_nxt = (SZ_W'(wp_r) + 1'b1 >= size) ? '0 : wp_r + 1'b1;
          end
          state_nxt = rjdl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rjdl_pkg::ST_IDLE;
      end
    endcase

    if (evt.size_wr) begin
      if (SZ_W'(wp_nxt) >= size_new) begin
        wp_nxt = '0;
      end
      if (SZ_W'(ri_nxt) >= size_new) begin
        ri_nxt   = '0;
        frac_nxt = '0;
      end
    end
    if (evt.count_wr) begin
      state_nxt    = rjdl_pkg::ST_CLEAR;
      clr_addr_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rjdl_pkg::ST_CLEAR;
      clr_addr_r  <= '0;
      wp_r        <= '0;
      ri_r        <= '0;
      frac_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      wp_r        <= wp_nxt;
      ri_r        <= ri_nxt;
      frac_r      <= frac_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    jit_r        <= jit_nxt;
    cls_r        <= cls_nxt;
    ijit_r       <= ijit_nxt;
    isample_r    <= isample_nxt;
    first_r      <= first_nxt;
    prod_r       <= prod_nxt;
    out_ch_r     <= out_ch_nxt;
    out_sample_r <= out_sample_nxt;
  end

  assign clearing   = (state_r == rjdl_pkg::ST_CLEAR);
  assign out_valid  = out_valid_r;
  assign out_ch     = out_ch_r;
  assign out_sample = out_sample_r;

endmodule

@@ hdl/random_jitter_delay_line.sv @@
// random_jitter_delay_line: top level of the per-channel jittered delay line
// depends on rjdl_pkg, rjdl_front, rjdl_fifo, rjdl_back and rjdl_ram
//
//   port group  direction  transfer on         payload
//   in_         input      in_valid&in_ready   channel, sample_in, random_draw
//   out_        output     out_valid&out_ready channel_out, sample_out
//   cfg_        input      cfg_we              cfg_index, cfg_wdata
//
// an active transaction passes back states IDLE, RD0, RD1, MUL and OUT; on
// channel 0 also JIT and POS (jitter saturation and position add); an inactive
// channel goes IDLE to OUT; one store read port, two reads per sample
// after reset and after every channel-count write the store is zeroed, one
// entry a cycle over all MAX_CHANNELS*STORE_DEPTH entries, with in_ready low
// a two-entry queue and the output register let input and output stall apart

module random_jitter_delay_line #(
  parameter int MAX_CHANNELS = 8,
  parameter int STORE_DEPTH  = 4096,
  parameter int SAMPLE_BITS  = 24
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [rjdl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rjdl_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [rjdl_pkg::CH_W-1:0]        in_channel,
  input  logic signed [SAMPLE_BITS-1:0]    in_sample_in,
  input  logic [rjdl_pkg::DRAW_W-1:0]      in_random_draw,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [rjdl_pkg::CH_W-1:0]        out_channel_out,
  output logic signed [SAMPLE_BITS-1:0]    out_sample_out
);

  localparam int SZ_W = $clog2(STORE_DEPTH + 1);
  localparam int CLS_W = $bits(rjdl_pkg::item_cls_t);
  localparam int QW = CLS_W + rjdl_pkg::JIT_W + SAMPLE_BITS;

  logic                          push, q_full, q_empty, q_pop, clearing;
  rjdl_pkg::item_cls_t           push_cls, q_cls;
  logic [rjdl_pkg::JIT_W-1:0]    push_jit, q_jit;
  logic [SAMPLE_BITS-1:0]        push_sample, q_sample;
  logic [SZ_W-1:0]               size, size_new;
  rjdl_pkg::cfg_evt_t            evt;
  logic [QW-1:0]                 q_wdata, q_rdata;

  rjdl_front #(
    .MAX_CHANNELS(MAX_CHANNELS),
    .STORE_DEPTH (STORE_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_channel     (in_channel),
    .in_sample_in   (in_sample_in),
    .in_random_draw (in_random_draw),
    .q_full         (q_full),
    .clearing       (clearing),
    .push           (push),
    .push_cls       (push_cls),
    .push_jit       (push_jit),
    .push_sample    (push_sample),
    .size           (size),
    .size_new       (size_new),
    .evt            (evt)
  );

  assign q_wdata = {push_cls, push_jit, push_sample};
  assign q_cls    = q_rdata[QW-1 -: CLS_W];
  assign q_jit    = q_rdata[SAMPLE_BITS +: rjdl_pkg::JIT_W];
  assign q_sample = q_rdata[SAMPLE_BITS-1:0];

  rjdl_fifo #(
    .WIDTH(QW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  rjdl_back #(
    .MAX_CHANNELS(MAX_CHANNELS),
    .STORE_DEPTH (STORE_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .evt        (evt),
    .size       (size),
    .size_new   (size_new),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .q_cls      (q_cls),
    .q_jit      (q_jit),
    .q_sample   (q_sample),
    .clearing   (clearing),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_ch     (out_channel_out),
    .out_sample (out_sample_out)
  );

endmodule
